// ----- rtl/assert_macros.svh -----
// assertion macros used by the converter controller i2a_ctrl
// clocked properties with active-low reset as the disable condition
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, generic failure message
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked property with a caller-supplied message string
`define ASSERT_CLK_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// ----- rtl/i2a_pkg.sv -----
// constants, command/status types and character helpers for the integer to ascii converter
// used by i2a_ctrl, i2a_dp and int_to_ascii_padded_core
`timescale 1ns / 1ps

package i2a_pkg;

    localparam int VALUE_BITS = 32;
    localparam int WIDTH_MAX  = 32;
    localparam int MAX_OUT    = 32;

    // decimal digits needed: ceil(bits * log10(2))
    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIG_BITS   = NDIG * 4;

    localparam int W_BITS   = $clog2(WIDTH_MAX + 1);
    localparam int ND_BITS  = $clog2(NDIG + 1);
    localparam int IDX_BITS = $clog2(NDIG);
    localparam int REM_BITS = $clog2(MAX_OUT + 1);
    localparam int CNT_BITS = $clog2(VALUE_BITS);
    localparam int SUM_BITS = $clog2(WIDTH_MAX + NDIG + 2);
    localparam int TOT_BITS = (SUM_BITS > REM_BITS) ? SUM_BITS : REM_BITS;

    localparam logic [1:0] FUNC_UDEC = 2'd0;
    localparam logic [1:0] FUNC_SDEC = 2'd1;
    localparam logic [1:0] FUNC_HEX  = 2'd2;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_LOW_A = 7'h61;
    localparam logic [6:0] CH_MINUS = 7'h2d;
    localparam logic [6:0] CH_SPACE = 7'h20;

    typedef struct packed {
        logic load;
        logic step;
        logic prep;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_hex;
        logic last_char;
    } t_dp_sts;

    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {3'b000, d};
        end else begin
            c = CH_LOW_A + {3'b000, d} - 7'd10;
        end
        return c;
    endfunction

endpackage

// ----- rtl/int_to_ascii_padded_core.sv -----
// decimal items go through conversion, layout and emission; hex skips conversion
// an item yields 1..32 characters; the next is taken after its last character
// the decimal conversion is a double-dabble loop, one operand bit per cycle
// characters then leave one per cycle through the output register unless stalled
// reset: synchronous active low, returns to idle with no character pending
`timescale 1ns / 1ps

module int_to_ascii_padded_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [i2a_pkg::VALUE_BITS-1:0] i_value,
    input  logic [1:0]                     i_func,
    input  logic [5:0]                     i_width,
    input  logic                           i_pad_zero,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [6:0]                     o_ascii_char,
    output logic                           o_last
);
    import i2a_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    i2a_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    i2a_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (i_value),
        .i_func       (i_func),
        .i_width      (i_width),
        .i_pad_zero   (i_pad_zero),
        .o_sts        (sts),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last)
    );

endmodule

// ----- rtl/i2a_dp.sv -----
// datapath: operand capture, double-dabble bcd conversion, field layout and character output
// depends on i2a_pkg; driven by command signals from i2a_ctrl
`timescale 1ns / 1ps

module i2a_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  i2a_pkg::t_dp_cmd                 i_cmd,
    input  logic [i2a_pkg::VALUE_BITS-1:0]   i_value,
    input  logic [1:0]                       i_func,
    input  logic [5:0]                       i_width,
    input  logic                             i_pad_zero,
    output i2a_pkg::t_dp_sts                 o_sts,
    output logic [6:0]                       o_ascii_char,
    output logic                             o_last
);
    import i2a_pkg::*;

    logic [VALUE_BITS-1:0] r_bin,     n_bin;
    logic [DIG_BITS-1:0]   r_digits,  n_digits;
    logic                  r_neg,     n_neg;
    logic [W_BITS-1:0]     r_w,       n_w;
    logic [6:0]            r_padc,    n_padc;
    logic [W_BITS-1:0]     r_pad_cnt, n_pad_cnt;
    logic [ND_BITS-1:0]    r_dig_rem, n_dig_rem;
    logic                  r_neg_pend, n_neg_pend;
    logic [REM_BITS-1:0]   r_rem,     n_rem;
    logic [6:0]            r_char,    n_char;
    logic                  r_last,    n_last;

    logic                  is_neg;
    logic [VALUE_BITS-1:0] mag;
    logic [W_BITS-1:0]     w_sat;
    logic [W_BITS-1:0]     w_eff;
    logic [DIG_BITS-1:0]   dig_adj;
    logic [ND_BITS-1:0]    nd;
    logic [TOT_BITS-1:0]   pad_t;
    logic [TOT_BITS-1:0]   total;
    logic [REM_BITS-1:0]   total_cap;
    logic [NDIG-1:0][3:0]  dig_arr;
    logic [IDX_BITS-1:0]   dig_idx;

    // operand capture
    always_comb begin
        is_neg = (i_func == FUNC_SDEC) && i_value[VALUE_BITS-1];
        mag    = is_neg ? (~i_value + 1'b1) : i_value;
        if (32'(i_width) > 32'(WIDTH_MAX)) begin
            w_sat = W_BITS'(WIDTH_MAX);
        end else begin
            w_sat = W_BITS'(i_width);
        end
        // the sign takes one place of the field
        w_eff = (is_neg && (w_sat != '0)) ? (w_sat - 1'b1) : w_sat;
    end

    // add-3 correction of every bcd digit before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_digits[4*i +: 4] >= 4'd5) begin
                dig_adj[4*i +: 4] = r_digits[4*i +: 4] + 4'd3;
            end else begin
                dig_adj[4*i +: 4] = r_digits[4*i +: 4];
            end
        end
    end

    // significant digit count, at least one so zero prints '0'
    always_comb begin
        nd = ND_BITS'(1);
        for (int i = 0; i < NDIG; i++) begin
            if (r_digits[4*i +: 4] != 4'd0) begin
                nd = ND_BITS'(i + 1);
            end
        end
        pad_t = (TOT_BITS'(r_w) > TOT_BITS'(nd)) ? (TOT_BITS'(r_w) - TOT_BITS'(nd)) : '0;
        total = TOT_BITS'(r_neg) + pad_t + TOT_BITS'(nd);
        total_cap = (total > TOT_BITS'(MAX_OUT)) ? REM_BITS'(MAX_OUT) : REM_BITS'(total);
    end

    assign dig_arr = r_digits;
    assign dig_idx = IDX_BITS'(r_dig_rem - 1'b1);

    always_comb begin
        n_bin      = r_bin;
        n_digits   = r_digits;
        n_neg      = r_neg;
        n_w        = r_w;
        n_padc     = r_padc;
        n_pad_cnt  = r_pad_cnt;
        n_dig_rem  = r_dig_rem;
        n_neg_pend = r_neg_pend;
        n_rem      = r_rem;
        n_char     = r_char;
        n_last     = r_last;

        if (i_cmd.load) begin
            n_bin    = mag;
            n_digits = i_func[1] ? DIG_BITS'(mag) : '0;
            n_neg    = is_neg;
            n_w      = w_eff;
            n_padc   = i_pad_zero ? CH_ZERO : CH_SPACE;
        end

        if (i_cmd.step) begin
            n_bin    = {r_bin[VALUE_BITS-2:0], 1'b0};
            n_digits = {dig_adj[DIG_BITS-2:0], r_bin[VALUE_BITS-1]};
        end

        if (i_cmd.prep) begin
            n_pad_cnt  = W_BITS'(pad_t);
            n_dig_rem  = nd;
            n_neg_pend = r_neg;
            n_rem      = total_cap;
        end

        if (i_cmd.emit) begin
            priority if (r_neg_pend) begin
                n_char     = CH_MINUS;
                n_neg_pend = 1'b0;
            end else if (r_pad_cnt != '0) begin
                n_char    = r_padc;
                n_pad_cnt = r_pad_cnt - 1'b1;
            end else begin
                n_char    = digit_char(dig_arr[dig_idx]);
                n_dig_rem = r_dig_rem - 1'b1;
            end
            n_rem  = r_rem - 1'b1;
            n_last = (r_rem == REM_BITS'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg_pend <= 1'b0;
            r_pad_cnt  <= '0;
            r_dig_rem  <= '0;
            r_rem      <= '0;
        end else begin
            r_neg_pend <= n_neg_pend;
            r_pad_cnt  <= n_pad_cnt;
            r_dig_rem  <= n_dig_rem;
            r_rem      <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin    <= n_bin;
        r_digits <= n_digits;
        r_neg    <= n_neg;
        r_w      <= n_w;
        r_padc   <= n_padc;
        r_char   <= n_char;
        r_last   <= n_last;
    end

    assign o_sts.in_hex    = i_func[1];
    assign o_sts.last_char = (r_rem == REM_BITS'(1));
    assign o_ascii_char    = r_char;
    assign o_last          = r_last;

endmodule

// ----- rtl/i2a_ctrl.sv -----
// controller: sequences load, bcd conversion, layout and emission; owns both handshakes
// depends on i2a_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2a_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  i2a_pkg::t_dp_sts i_sts,
    output i2a_pkg::t_dp_cmd o_cmd
);
    import i2a_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_PREP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS - 1);

    logic [1:0]          r_state,     n_state;
    logic [CNT_BITS-1:0] r_cnt,       n_cnt;
    logic                r_out_valid, n_out_valid;

    logic accept;
    logic slot_free;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    // output register can take a new character
    assign slot_free  = !r_out_valid || i_out_ready;

    assign o_cmd.load = accept;
    assign o_cmd.step = (r_state == ST_CONV);
    assign o_cmd.prep = (r_state == ST_PREP);
    assign o_cmd.emit = (r_state == ST_EMIT) && slot_free;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    // hex digits are the operand nibbles, no conversion pass
                    n_state = i_sts.in_hex ? ST_PREP : ST_CONV;
                end
            end
            ST_CONV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (o_cmd.emit && i_sts.last_char) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_CLK(a_conv_done, i_clk, i_rst_n, (r_state == ST_CONV && r_cnt == CNT_LAST) |=> (r_state == ST_PREP))
    `ASSERT_CLK(a_hex_skip, i_clk, i_rst_n, (accept && i_sts.in_hex) |=> (r_state == ST_PREP))
    `ASSERT_CLK_MSG(a_last_idle, i_clk, i_rst_n, (o_cmd.emit && i_sts.last_char) |=> (r_state == ST_IDLE && r_out_valid), "final character did not end the run")
    `ASSERT_CLK_MSG(a_no_overwrite, i_clk, i_rst_n, (r_out_valid && !i_out_ready) |-> !o_cmd.emit, "pending character overwritten")

endmodule

// ----- test/int_to_ascii_padded_checker.sv -----
// checker for int_to_ascii_padded_core: watches both channels, predicts the character run
// of each accepted item and compares every emitted character in order
// depends on i2a_pkg for the operand width, mode codes and character constants
`timescale 1ns / 1ps

module int_to_ascii_padded_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [i2a_pkg::VALUE_BITS-1:0] i_value,
    input  logic [1:0]                     i_func,
    input  logic [5:0]                     i_width,
    input  logic                           i_pad_zero,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [6:0]                     i_ascii_char,
    input  logic                           i_last,
    input  logic                           i_done,
    output int                             o_fail_count,
    output int                             o_chars_pending
);

    localparam int RUN_MAX = i2a_pkg::MAX_OUT;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } char_t;

    char_t exp_chars[$];
    int    fail_count        = 0;
    bit    leftover_reported = 1'b0;

    assign o_fail_count    = fail_count;
    assign o_chars_pending = exp_chars.size();

    task automatic report_mismatch(input string msg);
        $display("%0t checker: %s", $time, msg);
        fail_count++;
    endtask

    // builds the full run for one item and queues it, last flag on the final char
    task automatic predict_chars(input logic [i2a_pkg::VALUE_BITS-1:0] value,
                                 input logic [1:0] func, input logic [5:0] width,
                                 input logic pad_zero);
        logic [i2a_pkg::VALUE_BITS-1:0] mag;
        logic                           neg;
        logic [3:0]                     digs[24];
        logic [6:0]                     run[$];
        logic [6:0]                     padc;
        int                             nd;
        int                             fw;
        neg  = (func == i2a_pkg::FUNC_SDEC) && value[i2a_pkg::VALUE_BITS-1];
        mag  = neg ? (~value + 1'b1) : value;
        fw   = (width > i2a_pkg::WIDTH_MAX) ? i2a_pkg::WIDTH_MAX : int'(width);
        padc = pad_zero ? i2a_pkg::CH_ZERO : i2a_pkg::CH_SPACE;
        nd   = 0;
        if (mag == '0) begin
            digs[0] = 4'd0;
            nd = 1;
        end else begin
            // func bit 1 picks base 16, so mode three is hex too
            while (mag != '0) begin
                if (func[1]) begin
                    digs[nd] = mag[3:0];
                    mag = mag >> 4;
                end else begin
                    digs[nd] = 4'(mag % 10);
                    mag = mag / 10;
                end
                nd++;
            end
        end
        if (neg) begin
            run.push_back(i2a_pkg::CH_MINUS);
            if (fw > 0) fw--;
        end
        while (nd < fw) begin
            run.push_back(padc);
            fw--;
        end
        for (int i = nd - 1; i >= 0; i--) begin
            if (digs[i] < 4'd10) begin
                run.push_back(i2a_pkg::CH_ZERO + 7'(digs[i]));
            end else begin
                run.push_back(i2a_pkg::CH_LOW_A + 7'(digs[i]) - 7'd10);
            end
        end
        if (run.size() > RUN_MAX) run = run[0:RUN_MAX-1];
        for (int i = 0; i < run.size(); i++) begin
            exp_chars.push_back('{ch: run[i], last: (i == run.size() - 1)});
        end
    endtask

    always @(posedge i_clk) begin
        char_t want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (exp_chars.size() == 0) begin
                    report_mismatch($sformatf("char 0x%02h last %0b with nothing expected",
                                              i_ascii_char, i_last));
                end else begin
                    want = exp_chars.pop_front();
                    if (i_ascii_char !== want.ch) begin
                        report_mismatch($sformatf("ascii_char 0x%02h, expected 0x%02h",
                                                  i_ascii_char, want.ch));
                    end
                    if (i_last !== want.last) begin
                        report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
                                                  i_last, want.last, want.ch));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_chars(i_value, i_func, i_width, i_pad_zero);
            end
            if (i_done && !leftover_reported && exp_chars.size() != 0) begin
                report_mismatch($sformatf("%0d chars never emitted", exp_chars.size()));
                leftover_reported = 1'b1;
            end
        end
    end

endmodule

// ----- test/int_to_ascii_padded_core_tb.sv -----
// top of the int_to_ascii_padded_core testbench: clock, reset, item stimulus and verdict
// instantiates the core and int_to_ascii_padded_checker; needs i2a_pkg
`timescale 1ns / 1ps

module int_to_ascii_padded_core_tb;

    localparam int         CLK_HALF       = 6;
    localparam int         RESET_CYCLES   = 5;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         DRAIN_CYCLES   = 48;
    localparam int         RAND_ITEMS     = 258;
    localparam int         GAP_MAX        = 20;
    localparam logic [1:0] FUNC_HEX_ALT   = 2'd3;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           in_valid    = 1'b0;
    logic [i2a_pkg::VALUE_BITS-1:0] in_value    = '0;
    logic [1:0]                     in_func     = i2a_pkg::FUNC_UDEC;
    logic [5:0]                     in_width    = '0;
    logic                           in_pad_zero = 1'b0;
    logic                           out_ready   = 1'b0;
    logic                           chk_done    = 1'b0;
    logic                           in_ready;
    logic                           out_valid;
    logic [6:0]                     ascii_char;
    logic                           last;
    int                             fail_count;
    int                             chars_pending;
    int                             send_idle_pct = 20;
    int                             recv_idle_pct = 63;
    int                             stall_cycles  = 0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    int_to_ascii_padded_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_value      (in_value),
        .i_func       (in_func),
        .i_width      (in_width),
        .i_pad_zero   (in_pad_zero),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_ascii_char (ascii_char),
        .o_last       (last)
    );

    int_to_ascii_padded_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_value         (in_value),
        .i_func          (in_func),
        .i_width         (in_width),
        .i_pad_zero      (in_pad_zero),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_ascii_char    (ascii_char),
        .i_last          (last),
        .i_done          (chk_done),
        .o_fail_count    (fail_count),
        .o_chars_pending (chars_pending)
    );

    always @(posedge i_clk) begin
        out_ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("int_to_ascii_padded_core_tb: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // valid is only lowered when a gap follows, so back-to-back items keep it high
    task automatic send_item(input logic [31:0] v, input logic [1:0] f,
                             input logic [5:0] w, input logic p);
        int gap;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        in_value    <= v;
        in_func     <= f;
        in_width    <= w;
        in_pad_zero <= p;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (chars_pending != 0);
        @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        logic [31:0] v;
        logic [1:0]  f;
        logic [5:0]  w;
        repeat (count) begin
            case ($urandom_range(0, 5))
                0, 1: v = $urandom;
                2: v = $urandom_range(0, 20);
                3: v = 32'd1 << $urandom_range(0, 31);
                4: v = -32'($urandom_range(1, 20));
                default: begin
                    // near powers of ten, where the digit count changes
                    v = 32'd1;
                    repeat ($urandom_range(0, 9)) v = v * 10;
                    v = v + $urandom_range(0, 2) - 1;
                end
            endcase
            f = ($urandom_range(0, 9) < 9) ? 2'($urandom_range(0, 2)) : FUNC_HEX_ALT;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: w = 6'($urandom_range(0, 12));
                5, 6, 7: w = 6'($urandom_range(0, 32));
                default: w = 6'($urandom_range(0, 63));
            endcase
            send_item(v, f, w, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(32'd0, i2a_pkg::FUNC_UDEC, 6'd0, 1'b0);
        send_item(32'hFFFF_FFFF, i2a_pkg::FUNC_UDEC, 6'd0, 1'b0);
        send_item(32'hFFFF_FFFF, i2a_pkg::FUNC_UDEC, 6'd32, 1'b1);
        send_item(32'd1, i2a_pkg::FUNC_UDEC, 6'd32, 1'b0);
        send_item(32'h8000_0000, i2a_pkg::FUNC_SDEC, 6'd0, 1'b0);
        send_item(32'h8000_0000, i2a_pkg::FUNC_SDEC, 6'd12, 1'b1);
        send_item(32'h8000_0000, i2a_pkg::FUNC_SDEC, 6'd32, 1'b1);
        send_item(32'hFFFF_FFFF, i2a_pkg::FUNC_SDEC, 6'd5, 1'b1);
        send_item(32'hFFFF_FFFF, i2a_pkg::FUNC_SDEC, 6'd5, 1'b0);
        send_item(32'h7FFF_FFFF, i2a_pkg::FUNC_SDEC, 6'd0, 1'b0);
        send_item(32'd0, i2a_pkg::FUNC_SDEC, 6'd1, 1'b1);
        send_item(-32'd5, i2a_pkg::FUNC_SDEC, 6'd1, 1'b1);
        send_item(32'd42, i2a_pkg::FUNC_SDEC, 6'd4, 1'b1);
        send_item(32'hDEAD_BEEF, i2a_pkg::FUNC_HEX, 6'd0, 1'b0);
        send_item(32'd0, i2a_pkg::FUNC_HEX, 6'd8, 1'b1);
        send_item(32'hFFFF_FFFF, i2a_pkg::FUNC_HEX, 6'd32, 1'b0);
        send_item(32'h0123_ABCD, i2a_pkg::FUNC_HEX, 6'd10, 1'b1);
        // mode three behaves as hex, sign bit ignored
        send_item(32'h0000_CAFE, FUNC_HEX_ALT, 6'd6, 1'b1);
        send_item(32'h8000_0000, FUNC_HEX_ALT, 6'd0, 1'b0);
        // widths past the maximum saturate
        send_item(32'd7, i2a_pkg::FUNC_UDEC, 6'd63, 1'b0);
        send_item(-32'd7, i2a_pkg::FUNC_SDEC, 6'd33, 1'b1);
        send_item(32'hA, i2a_pkg::FUNC_HEX, 6'd40, 1'b1);

        // hold off until the converter has emitted everything
        in_valid <= 1'b0;
        wait_drained();

        send_random(RAND_ITEMS / 3);
        send_idle_pct = 63;
        recv_idle_pct = 20;
        send_random(RAND_ITEMS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(RAND_ITEMS - 2 * (RAND_ITEMS / 3));
        in_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        chk_done <= 1'b1;
        @(posedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("int_to_ascii_padded_core_tb: PASS");
        end else begin
            $display("int_to_ascii_padded_core_tb: FAIL");
        end
        $finish;
    end

endmodule
